// File: hdl/bic_pkg.sv
// ----------------------------------------------------------------------------
// bic_pkg: types and constants of the box IoU cost unit
// Request layouts for both channels and the fixed Q1.16 constants.
// ----------------------------------------------------------------------------
package bic_pkg;

	localparam int unsigned RatioW = 17;
	localparam int unsigned DivSteps = 17;

	localparam logic [RatioW-1:0] Q16_ONE = 17'd65536;
	localparam logic [RatioW-1:0] COST_GATED = 17'h1FFFF;

	typedef struct packed {
		logic signed [15:0] track_x;
		logic signed [15:0] track_y;
		logic [14:0] track_w;
		logic [14:0] track_h;
		logic signed [15:0] cand_x;
		logic signed [15:0] cand_y;
		logic [14:0] cand_w;
		logic [14:0] cand_h;
		logic track_gated;
	} box_in_t;

	typedef struct packed {
		logic [RatioW-1:0] overlap_ratio;
		logic [RatioW-1:0] match_cost;
		logic gated_flag;
	} box_out_t;

endpackage

// File: hdl/box_iou_cost_unit.sv
// ----------------------------------------------------------------------------
// box_iou_cost_unit: intersection-over-union matching cost of one box pair
// Each request pairs a track box and a candidate box; the block returns IoU in
// Q1.16, the cost 1.0 - IoU (all ones for a gated track) and a gated flag. Fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken on the input channel when in_valid and in_ready are both
// high; its result appears on the output channel and is taken when out_valid
// and out_ready are both high. Results leave in request order, one per request.
// Results pass through 21 register stages from acceptance to out_valid:
// one stage for the overlap extents, one for the three 15 by 15 area products,
// one for the union, 17 for the restoring divider (one quotient bit a stage) and
// the output register.
// Throughput is one request per cycle while out_ready is high; the divider chain sets the depth.
// Every stage has its own valid bit and holds only while the stage behind it is
// full and held, so bubbles close up while the receiver stalls and in_ready
// drops only once the whole pipeline is full. A stall loses and repeats nothing.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module box_iou_cost_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bic_pkg::box_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bic_pkg::box_out_t out_data
);
	import bic_pkg::*;

	localparam int unsigned NumStages = DivSteps + 4;
	localparam int unsigned DivBase = 3;

	typedef struct packed {
		logic [14:0] dx;
		logic [14:0] dy;
		logic [14:0] tw;
		logic [14:0] th;
		logic [14:0] cw;
		logic [14:0] ch;
		logic gated;
	} ext_t;

	typedef struct packed {
		logic [29:0] inter;
		logic [29:0] area_t;
		logic [29:0] area_c;
		logic gated;
	} area_t;

	typedef struct packed {
		logic [29:0] inter;
		logic [30:0] uni;
		logic zero;
		logic gated;
	} uni_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [30:0] dvs;
		logic [RatioW-1:0] quo;
		logic zero;
		logic gated;
	} div_t;

	logic [NumStages-1:0] vld;
	logic [NumStages:0] en;

	ext_t ext_d, ext_s1;
	area_t area_s2;
	uni_t uni_s3;
	div_t div_d [DivSteps];
	div_t div_s4 [DivSteps];   // entry k is pipeline stage 4 + k
	box_out_t res_d, res_s21;

	// A stage may load when it is empty or when the stage behind it moves.
	assign en[NumStages] = out_ready;
	genvar gk;
	generate
		for (gk = 0; gk < NumStages; gk++) begin : g_en
			assign en[gk] = !vld[gk] || en[gk+1];
		end
	endgenerate

	assign in_ready = en[0];
	assign out_valid = vld[NumStages-1];
	assign out_data = res_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) begin
				vld[0] <= in_valid;
			end
			for (int k = 1; k < NumStages; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// Stage 1: overlap extents, clipped to zero.
	always_comb begin
		logic signed [16:0] t_r, c_r, hi_x, t_b, c_b, hi_y;
		logic signed [15:0] lo_x, lo_y;
		logic signed [17:0] d_x, d_y;
		t_r = 17'(in_data.track_x) + $signed({2'b00, in_data.track_w});
		c_r = 17'(in_data.cand_x) + $signed({2'b00, in_data.cand_w});
		t_b = 17'(in_data.track_y) + $signed({2'b00, in_data.track_h});
		c_b = 17'(in_data.cand_y) + $signed({2'b00, in_data.cand_h});
		hi_x = (t_r < c_r) ? t_r : c_r;
		hi_y = (t_b < c_b) ? t_b : c_b;
		lo_x = (in_data.track_x > in_data.cand_x) ? in_data.track_x : in_data.cand_x;
		lo_y = (in_data.track_y > in_data.cand_y) ? in_data.track_y : in_data.cand_y;
		d_x = 18'(hi_x) - 18'(lo_x);
		d_y = 18'(hi_y) - 18'(lo_y);
		// An extent never exceeds the narrower box, so 15 bits hold it.
		ext_d.dx = (d_x > 18'sd0) ? d_x[14:0] : 15'd0;
		ext_d.dy = (d_y > 18'sd0) ? d_y[14:0] : 15'd0;
		ext_d.tw = in_data.track_w;
		ext_d.th = in_data.track_h;
		ext_d.cw = in_data.cand_w;
		ext_d.ch = in_data.cand_h;
		ext_d.gated = in_data.track_gated;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ext_s1 <= ext_d;
		end
	end

	// Stage 2: intersection and box areas.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			area_s2.inter <= 30'(ext_s1.dx) * 30'(ext_s1.dy);
			area_s2.area_t <= 30'(ext_s1.tw) * 30'(ext_s1.th);
			area_s2.area_c <= 30'(ext_s1.cw) * 30'(ext_s1.ch);
			area_s2.gated <= ext_s1.gated;
		end
	end

	// Stage 3: union.
	always_ff @(posedge clk) begin
		logic [30:0] uni;
		if (en[2]) begin
			uni = 31'(area_s2.area_t) + 31'(area_s2.area_c) - 31'(area_s2.inter);
			uni_s3.inter <= area_s2.inter;
			uni_s3.uni <= uni;
			uni_s3.zero <= (uni == 31'd0);
			uni_s3.gated <= area_s2.gated;
		end
	end

	// Divider, first stage: the intersection never exceeds the union, so the
	// integer quotient bit is a single compare without a shift.
	always_comb begin
		logic bit0;
		bit0 = (31'(uni_s3.inter) >= uni_s3.uni);
		div_d[0].rem = bit0 ? (31'(uni_s3.inter) - uni_s3.uni) : 31'(uni_s3.inter);
		div_d[0].dvs = uni_s3.uni;
		div_d[0].quo = {{(RatioW-1){1'b0}}, bit0};
		div_d[0].zero = uni_s3.zero;
		div_d[0].gated = uni_s3.gated;
	end

	// Remaining stages: one fraction bit each; the remainder stays below the
	// divisor, so its double fits in 32 bits.
	generate
		for (gk = 1; gk < DivSteps; gk++) begin : g_div
			always_comb begin
				logic [31:0] r2;
				logic qb;
				r2 = {div_s4[gk-1].rem, 1'b0};
				qb = (r2 >= {1'b0, div_s4[gk-1].dvs});
				div_d[gk].rem = qb ? 31'(r2 - {1'b0, div_s4[gk-1].dvs}) : r2[30:0];
				div_d[gk].dvs = div_s4[gk-1].dvs;
				div_d[gk].quo = {div_s4[gk-1].quo[RatioW-2:0], qb};
				div_d[gk].zero = div_s4[gk-1].zero;
				div_d[gk].gated = div_s4[gk-1].gated;
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		for (int k = 0; k < DivSteps; k++) begin
			if (en[DivBase+k]) begin
				div_s4[k] <= div_d[k];
			end
		end
	end

	// Output stage: zero union and gated tracks override the quotient.
	always_comb begin
		div_t last;
		last = div_s4[DivSteps-1];
		res_d.overlap_ratio = (last.gated || last.zero) ? '0 : last.quo;
		res_d.match_cost = last.gated ? COST_GATED : (Q16_ONE - res_d.overlap_ratio);
		res_d.gated_flag = last.gated;
	end

	always_ff @(posedge clk) begin
		if (en[NumStages-1]) begin
			res_s21 <= res_d;
		end
	end

endmodule

// File: verif/tb_box_iou_cost_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_iou_cost_unit: self-checking bench for the box IoU cost unit
// Box pairs are queued by a stimulus process and presented by a clocked driver.
// A predictor computes the expected IoU, cost and gated flag for each accepted
// request. A clocked monitor compares every result with the oldest prediction.
// Sender gaps and receiver stalls change across three phases.
// ----------------------------------------------------------------------------
module tb_box_iou_cost_unit;
	import bic_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	box_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	box_out_t out_data;

	box_in_t  pending_boxes[$];
	box_out_t expected_costs[$];
	int       mismatch_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	box_iou_cost_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #4 clk = ~clk;

	function automatic longint overlap_extent(longint a0, longint alen, longint b0,
		longint blen);
		longint hi;
		longint lo;
		hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
		lo = (a0 > b0) ? a0 : b0;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	function automatic box_out_t predict_iou_cost(box_in_t req);
		box_out_t res;
		longint inter;
		longint uni;
		longint ratio;
		res = '0;
		if (req.track_gated) begin
			res.overlap_ratio = '0;
			res.match_cost = COST_GATED;
			res.gated_flag = 1'b1;
			return res;
		end
		inter = overlap_extent(longint'(req.track_x), longint'(req.track_w),
			longint'(req.cand_x), longint'(req.cand_w)) *
			overlap_extent(longint'(req.track_y), longint'(req.track_h),
			longint'(req.cand_y), longint'(req.cand_h));
		uni = longint'(req.track_w) * longint'(req.track_h) +
			longint'(req.cand_w) * longint'(req.cand_h) - inter;
		ratio = (uni == 0) ? 0 : (inter * 65536) / uni;
		if (ratio > 65536)
			ratio = 65536;
		res.overlap_ratio = RatioW'(ratio);
		res.match_cost = Q16_ONE - RatioW'(ratio);
		res.gated_flag = 1'b0;
		return res;
	endfunction

	function automatic box_in_t pair_of(int tx, int ty, int tw, int th, int cx, int cy,
		int cw, int ch, bit gated);
		box_in_t b;
		b.track_x = 16'(tx);
		b.track_y = 16'(ty);
		b.track_w = 15'(tw);
		b.track_h = 15'(th);
		b.cand_x = 16'(cx);
		b.cand_y = 16'(cy);
		b.cand_w = 15'(cw);
		b.cand_h = 15'(ch);
		b.track_gated = gated;
		return b;
	endfunction

	// Mostly overlapping pairs of modest size, since those exercise the divider
	// with nontrivial quotients; the rest are fully random, gated or degenerate.
	function automatic box_in_t random_pair();
		box_in_t b;
		int roll;
		int span;
		roll = $urandom_range(99);
		b = '0;
		if (roll < 65) begin
			b.track_x = 16'(int'($urandom_range(65535)) - 32768);
			b.track_y = 16'(int'($urandom_range(65535)) - 32768);
			b.track_w = ($urandom_range(9) == 0) ? 15'($urandom_range(32767)) :
				15'($urandom_range(300));
			b.track_h = ($urandom_range(9) == 0) ? 15'($urandom_range(32767)) :
				15'($urandom_range(300));
			b.cand_w = ($urandom_range(3) == 0) ? b.track_w :
				15'($urandom_range(32767) % (b.track_w + 40));
			b.cand_h = ($urandom_range(3) == 0) ? b.track_h :
				15'($urandom_range(32767) % (b.track_h + 40));
			span = int'(b.track_w) + 16;
			b.cand_x = ($urandom_range(7) == 0) ? b.track_x :
				16'(int'(b.track_x) + int'($urandom_range(2 * span)) - span);
			span = int'(b.track_h) + 16;
			b.cand_y = ($urandom_range(7) == 0) ? b.track_y :
				16'(int'(b.track_y) + int'($urandom_range(2 * span)) - span);
		end else begin
			b.track_x = 16'($urandom());
			b.track_y = 16'($urandom());
			b.track_w = 15'($urandom());
			b.track_h = 15'($urandom());
			b.cand_x = 16'($urandom());
			b.cand_y = 16'($urandom());
			b.cand_w = 15'($urandom());
			b.cand_h = 15'($urandom());
			if (roll >= 85 && roll < 93) begin
				b.track_gated = 1'b1;
			end else if (roll >= 93) begin
				if ($urandom_range(1))
					b.track_w = '0;
				else
					b.track_h = '0;
				if ($urandom_range(1))
					b.cand_w = '0;
			end
		end
		return b;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 40)
			$display("%0t: MISMATCH %s", $time, msg);
		mismatch_count++;
	endtask

	// Driver: a request stays on the bus unchanged until it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				expected_costs.push_back(predict_iou_cost(in_data));
			if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_boxes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		box_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_costs.size() == 0) begin
				report_mismatch($sformatf("result %p with no request pending", out_data));
			end else begin
				want = expected_costs.pop_front();
				if (out_data.overlap_ratio !== want.overlap_ratio)
					report_mismatch($sformatf("overlap_ratio got %0d expected %0d",
						out_data.overlap_ratio, want.overlap_ratio));
				if (out_data.match_cost !== want.match_cost)
					report_mismatch($sformatf("match_cost got %0d expected %0d",
						out_data.match_cost, want.match_cost));
				if (out_data.gated_flag !== want.gated_flag)
					report_mismatch($sformatf("gated_flag got %0b expected %0b",
						out_data.gated_flag, want.gated_flag));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("tb_box_iou_cost_unit: done, errors");
		$finish;
	end

	initial begin
		int phase;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero union, full-range identical boxes, extreme edges.
		pending_boxes.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_boxes.push_back(pair_of(-32768, -32768, 32767, 32767,
			-32768, -32768, 32767, 32767, 0));
		pending_boxes.push_back(pair_of(32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767, 0));
		pending_boxes.push_back(pair_of(-32768, -32768, 32767, 32767,
			32767, 32767, 32767, 32767, 0));
		pending_boxes.push_back(pair_of(-32768, 0, 32767, 50, -1, 0, 32767, 50, 0));
		// Touching and disjoint boxes.
		pending_boxes.push_back(pair_of(0, 0, 10, 10, 10, 0, 10, 10, 0));
		pending_boxes.push_back(pair_of(0, 0, 10, 10, 0, 10, 10, 10, 0));
		pending_boxes.push_back(pair_of(-100, -100, 5, 5, 100, 100, 5, 5, 0));
		// Containment, partial overlap and a truncated quotient.
		pending_boxes.push_back(pair_of(0, 0, 100, 100, 10, 10, 50, 50, 0));
		pending_boxes.push_back(pair_of(-500, -400, 20, 30, -600, -500, 32767, 32767, 0));
		pending_boxes.push_back(pair_of(0, 0, 3, 3, 1, 1, 3, 3, 0));
		pending_boxes.push_back(pair_of(0, 0, 3, 1, 0, 0, 1, 1, 0));
		pending_boxes.push_back(pair_of(-32768, -32768, 32767, 32767, 0, 0, 1, 1, 0));
		// One box with zero area, then both with zero area apart.
		pending_boxes.push_back(pair_of(0, 0, 100, 100, 20, 20, 0, 40, 0));
		pending_boxes.push_back(pair_of(5, 5, 0, 30, 50, 50, 30, 0, 0));
		pending_boxes.push_back(pair_of(0, 0, 0, 0, 0, 0, 32767, 0, 0));
		// Gated tracks ignore the box fields entirely.
		pending_boxes.push_back(pair_of(-1, -1, 32767, 32767, -1, -1, 32767, 32767, 1));
		pending_boxes.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 1));
		pending_boxes.push_back(pair_of(0, 0, 100, 100, 0, 0, 100, 100, 1));

		for (phase = 0; phase < 3; phase++) begin
			@(negedge clk);
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 71 : 0;
			recv_stall_pct = (phase == 0) ? 71 : (phase == 1) ? 11 : 0;
			repeat ((phase == 0) ? 620 : 630)
				pending_boxes.push_back(random_pair());
			// Hold off the next phase until every result has come back.
			while (pending_boxes.size() != 0 || in_valid || expected_costs.size() != 0)
				@(negedge clk);
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_costs.size() == 0)
			$display("tb_box_iou_cost_unit: done, clean");
		else
			$display("tb_box_iou_cost_unit: done, errors");
		$finish;
	end

endmodule
